// File: src/hbs_pkg.sv
// shared types and sizing constants for the bucketed hash set
package hbs_pkg;

    localparam int BUCKETS = 10;
    localparam int WAYS    = 8;
    localparam int KEY_W   = 31;

    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W  = $clog2(WAYS + 1);
    localparam int DEPTH   = BUCKETS * WAYS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // scaled reciprocal of the bucket count, exact over the whole key range
    localparam int RECIP_W     = KEY_W + 1;
    localparam int RECIP_SHIFT = KEY_W + $clog2(BUCKETS);
    localparam int PROD_W      = KEY_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic found;
        logic overflow;
    } t_rsp;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] rem;
    } t_mod_stat;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [BKT_W-1:0] bucket;
        logic [WAY_W-1:0] way;
    } t_store_req;

endpackage

// File: src/hbs_mod_unit.sv
// remainder of the key by the bucket count: reciprocal multiply, then multiply back
module hbs_mod_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hbs_pkg::KEY_W-1:0] i_key,
    output hbs_pkg::t_mod_stat        o_stat
);

    logic                       r_ph1;
    logic                       r_ph2;
    logic                       r_done;
    logic [hbs_pkg::KEY_W-1:0]  r_key;
    logic [hbs_pkg::KEY_W-1:0]  r_quot;
    logic [hbs_pkg::BKT_W-1:0]  r_rem;

    logic [hbs_pkg::PROD_W-1:0] prod;
    logic [hbs_pkg::KEY_W-1:0]  n_quot;
    logic [hbs_pkg::KEY_W-1:0]  back;
    logic [hbs_pkg::KEY_W-1:0]  diff;
    logic [hbs_pkg::BKT_W-1:0]  n_rem;

    // quotient from the reciprocal, then key minus quotient times bucket count
    assign prod   = hbs_pkg::PROD_W'(r_key) * hbs_pkg::PROD_W'(hbs_pkg::RECIP);
    assign n_quot = hbs_pkg::KEY_W'(prod >> hbs_pkg::RECIP_SHIFT);
    assign back   = r_quot * hbs_pkg::KEY_W'(hbs_pkg::BUCKETS);
    assign diff   = r_key - back;
    assign n_rem  = diff[hbs_pkg::BKT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1  <= 1'b0;
            r_ph2  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph1  <= i_start;
            r_ph2  <= r_ph1;
            r_done <= r_ph2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_ph1) begin
            r_quot <= n_quot;
        end
        if (r_ph2) begin
            r_rem <= n_rem;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule

// File: src/hbs_store.sv
// key memory with registered read and per-bucket fill counters
module hbs_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hbs_pkg::t_store_req        i_req,
    input  logic [hbs_pkg::KEY_W-1:0]  i_wr_key,
    output logic [hbs_pkg::FILL_W-1:0] o_fill,
    output logic [hbs_pkg::KEY_W-1:0]  o_rd_key
);

    logic [hbs_pkg::KEY_W-1:0]  r_mem [hbs_pkg::DEPTH];
    logic [hbs_pkg::FILL_W-1:0] r_fill [hbs_pkg::BUCKETS];
    logic [hbs_pkg::KEY_W-1:0]  r_rd_key;
    logic [hbs_pkg::ADDR_W-1:0] addr;

    assign addr = hbs_pkg::ADDR_W'(i_req.bucket) * hbs_pkg::ADDR_W'(hbs_pkg::WAYS)
                + hbs_pkg::ADDR_W'(i_req.way);

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[addr] <= i_wr_key;
        end
        if (i_req.rd_en) begin
            r_rd_key <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hbs_pkg::BUCKETS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (i_req.wr_en) begin
            r_fill[i_req.bucket] <= r_fill[i_req.bucket] + hbs_pkg::FILL_W'(1);
        end
    end

    assign o_fill   = r_fill[i_req.bucket];
    assign o_rd_key = r_rd_key;

endmodule

// File: src/bucketed_hash_set.sv
// top level of the bucketed hash set: request sequencer and result register
//
//  channel   signals                       payload
//  request   i_valid / o_ready             i_req  (req_type, key)
//  response  o_valid / i_ready             o_rsp  (found, overflow)
//
//  an insert runs from acceptance to result through finding the bucket
//  (reciprocal multiply, multiply back and subtract, bucket latch), a fill lookup and the load
//  a search then compares each stored entry in turn, with a last step when none matches
//  o_ready is high only while no request is in flight; a stalled output holds the
//  sequencer only when the next result is ready and the register is still full
//  reset clears the fill counters at once, no clearing pass
module bucketed_hash_set (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hbs_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output hbs_pkg::t_rsp o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                 r_state, n_state;
    logic                       r_type;
    logic [hbs_pkg::KEY_W-1:0]  r_key;
    logic [hbs_pkg::BKT_W-1:0]  r_bkt, n_bkt;
    logic [hbs_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [hbs_pkg::FILL_W-1:0] r_way, n_way;
    logic                       r_found, n_found;
    logic                       r_ovf, n_ovf;
    logic                       r_out_vld;
    hbs_pkg::t_rsp              r_rsp;

    logic                       in_fire;
    logic                       out_load;
    hbs_pkg::t_mod_stat         mod_stat;
    hbs_pkg::t_store_req        st_req;
    logic [hbs_pkg::FILL_W-1:0] st_fill;
    logic [hbs_pkg::KEY_W-1:0]  st_rd_key;

    assign o_ready  = (r_state == S_IDLE);
    assign in_fire  = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_vld || i_ready);

    hbs_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_key   (i_req.key),
        .o_stat  (mod_stat)
    );

    hbs_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (st_req),
        .i_wr_key (r_key),
        .o_fill   (st_fill),
        .o_rd_key (st_rd_key)
    );

    always_comb begin
        n_state      = r_state;
        n_bkt        = r_bkt;
        n_fill       = r_fill;
        n_way        = r_way;
        n_found      = r_found;
        n_ovf        = r_ovf;
        st_req.rd_en = 1'b0;
        st_req.wr_en = 1'b0;
        st_req.bucket = r_bkt;
        st_req.way    = r_way[hbs_pkg::WAY_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_MOD;
                    n_found = 1'b0;
                    n_ovf   = 1'b0;
                    n_way   = '0;
                end
            end
            S_MOD: begin
                if (mod_stat.done) begin
                    n_bkt   = mod_stat.rem;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_fill = st_fill;
                if (r_type == hbs_pkg::REQ_INSERT) begin
                    if (st_fill >= hbs_pkg::FILL_W'(hbs_pkg::WAYS)) begin
                        n_ovf = 1'b1;
                    end else begin
                        st_req.wr_en = 1'b1;
                        st_req.way   = st_fill[hbs_pkg::WAY_W-1:0];
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_way == r_fill) begin
                    n_state = S_DONE;
                end else begin
                    st_req.rd_en = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                if (st_rd_key == r_key) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_way   = r_way + hbs_pkg::FILL_W'(1);
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_type <= i_req.req_type;
            r_key  <= i_req.key;
        end
        r_bkt   <= n_bkt;
        r_fill  <= n_fill;
        r_way   <= n_way;
        r_found <= n_found;
        r_ovf   <= n_ovf;
        if (out_load) begin
            r_rsp.found    <= r_found;
            r_rsp.overflow <= r_ovf;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_ready)
        else $error("request taken while a transaction is in flight");

    a_write_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_req.wr_en |-> (r_type == hbs_pkg::REQ_INSERT) &&
                         (st_fill < hbs_pkg::FILL_W'(hbs_pkg::WAYS)))
        else $error("key write outside an insert with room");

    a_cmp_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> $past(st_req.rd_en))
        else $error("compare without a preceding read");

    a_mod_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_stat.done |-> (r_state == S_MOD))
        else $error("remainder finished outside its wait state");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rsp.found && o_rsp.overflow))
        else $error("found and overflow both set");
`endif

endmodule

// File: tb/sv/bucketed_hash_set_tb.sv
// self-checking testbench for the bucketed hash set: insert and search traffic
`timescale 1ns / 100ps

module bucketed_hash_set_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 800;
    localparam logic [hbs_pkg::KEY_W-1:0] KEY_MAX = {hbs_pkg::KEY_W{1'b1}};

    // shadow copy of the bucket contents and the responses still owed
    class hash_set_shadow;
        int unsigned               fill [hbs_pkg::BUCKETS];
        logic [hbs_pkg::KEY_W-1:0] keys [hbs_pkg::BUCKETS][hbs_pkg::WAYS];
        hbs_pkg::t_rsp             pending_rsp [$];
        int                        mismatches;

        function new();
            foreach (fill[b]) begin
                fill[b] = 0;
            end
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        function void note_request(hbs_pkg::t_req req);
            int unsigned   b;
            hbs_pkg::t_rsp want;
            b    = req.key % hbs_pkg::BUCKETS;
            want = '0;
            if (req.req_type == hbs_pkg::REQ_SEARCH) begin
                for (int w = 0; w < fill[b]; w++) begin
                    if (keys[b][w] == req.key) begin
                        want.found = 1'b1;
                    end
                end
            end else if (fill[b] >= hbs_pkg::WAYS) begin
                want.overflow = 1'b1;
            end else begin
                keys[b][fill[b]] = req.key;
                fill[b]++;
            end
            pending_rsp.push_back(want);
        endfunction

        task check_response(hbs_pkg::t_rsp got);
            hbs_pkg::t_rsp want;
            if (pending_rsp.size() == 0) begin
                report_mismatch("response with no request outstanding");
                return;
            end
            want = pending_rsp.pop_front();
            if (got.found !== want.found) begin
                report_mismatch($sformatf("found: got %b, want %b", got.found, want.found));
            end
            if (got.overflow !== want.overflow) begin
                report_mismatch($sformatf("overflow: got %b, want %b",
                                          got.overflow, want.overflow));
            end
        endtask
    endclass

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_ready = 1'b0;
    hbs_pkg::t_req i_req   = '0;
    logic          o_ready;
    logic          o_valid;
    hbs_pkg::t_rsp o_rsp;

    hash_set_shadow shadow = new();
    int  idle_cycles = 0;
    bit  burst_mode  = 1'b0;
    bit  rx_hold     = 1'b0;

    bucketed_hash_set dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(input logic kind, input logic [hbs_pkg::KEY_W-1:0] key);
        int            gap;
        hbs_pkg::t_req req;
        gap          = burst_mode ? 0 : pick_gap();
        req.req_type = kind;
        req.key      = key;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic [hbs_pkg::KEY_W-1:0] key_in_bucket(int unsigned b);
        return hbs_pkg::KEY_W'($urandom_range(0, 214748363) * hbs_pkg::BUCKETS + b);
    endfunction

    // a key already stored if the chosen bucket has one, else a fresh one
    function automatic logic [hbs_pkg::KEY_W-1:0] stored_key();
        int unsigned b;
        b = $urandom_range(0, hbs_pkg::BUCKETS - 1);
        if (shadow.fill[b] == 0) return key_in_bucket(b);
        return shadow.keys[b][$urandom_range(0, shadow.fill[b] - 1)];
    endfunction

    task automatic random_traffic();
        int                        r;
        logic [hbs_pkg::KEY_W-1:0] key;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            burst_mode = ((n / 100) % 4) == 2;
            if (n == RANDOM_ITEMS / 2) begin
                rx_hold = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 20) begin
                key = ($urandom_range(0, 1) == 0) ? hbs_pkg::KEY_W'($urandom())
                                                  : hbs_pkg::KEY_W'($urandom_range(0, 999));
                send_request(hbs_pkg::REQ_INSERT, key);
            end else begin
                if (r < 56) key = stored_key();
                else if (r < 76) key = key_in_bucket($urandom_range(0, hbs_pkg::BUCKETS - 1));
                else key = hbs_pkg::KEY_W'($urandom());
                send_request(hbs_pkg::REQ_SEARCH, key);
            end
        end
    endtask

    // receiver side: random stalls, bursts of steady ready, one long hold-off
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold) begin
                rx_hold = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (burst_mode) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // transaction monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) shadow.note_request(i_req);
            if (o_valid && i_ready) shadow.check_response(o_rsp);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("[bucketed_hash_set] ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set, both key extremes, duplicates, a full bucket
        send_request(hbs_pkg::REQ_SEARCH, '0);
        send_request(hbs_pkg::REQ_INSERT, '0);
        send_request(hbs_pkg::REQ_SEARCH, '0);
        send_request(hbs_pkg::REQ_INSERT, KEY_MAX);
        send_request(hbs_pkg::REQ_SEARCH, KEY_MAX);
        send_request(hbs_pkg::REQ_SEARCH, KEY_MAX - hbs_pkg::KEY_W'(hbs_pkg::BUCKETS));
        send_request(hbs_pkg::REQ_INSERT, '0);
        send_request(hbs_pkg::REQ_INSERT, 31'd3);
        send_request(hbs_pkg::REQ_INSERT, KEY_MAX - 31'd4);
        for (int k = 1; k <= 6; k++) begin
            send_request(hbs_pkg::REQ_INSERT, hbs_pkg::KEY_W'(k * hbs_pkg::BUCKETS + 3));
        end
        send_request(hbs_pkg::REQ_INSERT, 31'd73);
        send_request(hbs_pkg::REQ_SEARCH, 31'd63);
        send_request(hbs_pkg::REQ_SEARCH, 31'd73);
        send_request(hbs_pkg::REQ_SEARCH, KEY_MAX - 31'd4);
        send_request(hbs_pkg::REQ_SEARCH, 31'd5);
        send_request(hbs_pkg::REQ_INSERT, 31'h2AAA_AAAA);
        send_request(hbs_pkg::REQ_SEARCH, 31'h5555_5555);
        send_request(hbs_pkg::REQ_SEARCH, 31'h2AAA_AAAA);

        random_traffic();
        i_valid <= 1'b0;

        while (shadow.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (shadow.mismatches == 0 && shadow.pending_rsp.size() == 0) begin
            $display("[bucketed_hash_set] OK");
        end else begin
            $display("[bucketed_hash_set] ERROR");
        end
        $finish;
    end

endmodule
